FILE: rtl/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg: shared types and constants for the IMU complementary filter
// Formats, register indexes, CORDIC arctangent table and helper functions.
// ----------------------------------------------------------------------------
package icf_pkg;

  localparam int CordicSteps   = 16;
  localparam int AngleFracBits = 16;
  localparam int TabLen        = 24;
  localparam int DegShift      = 24 - AngleFracBits;
  localparam int StepW         = $clog2(CordicSteps + 1);

  // CORDIC working width: 16-bit count scaled by 2^16, plus growth.
  localparam int CW = 36;
  // angle accumulator, Q8.24 degrees plus sign and headroom
  localparam int AW = 34;

  localparam logic signed [AW-1:0] Deg180Q24 = AW'(64'sd180 * 64'sd16777216);

  typedef enum logic [2:0] {
    REG_NOISE   = 3'd0,
    REG_MAG_LO  = 3'd1,
    REG_MAG_HI  = 3'd2,
    REG_WEIGHT  = 3'd3,
    REG_MAX_DT  = 3'd4
  } reg_idx_e;

  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  atan_tab = AW'(754974720);
      5'd1:  atan_tab = AW'(445687602);
      5'd2:  atan_tab = AW'(235489088);
      5'd3:  atan_tab = AW'(119537938);
      5'd4:  atan_tab = AW'(60000934);
      5'd5:  atan_tab = AW'(30029717);
      5'd6:  atan_tab = AW'(15018523);
      5'd7:  atan_tab = AW'(7509720);
      5'd8:  atan_tab = AW'(3754917);
      5'd9:  atan_tab = AW'(1877466);
      5'd10: atan_tab = AW'(938734);
      5'd11: atan_tab = AW'(469367);
      5'd12: atan_tab = AW'(234684);
      5'd13: atan_tab = AW'(117342);
      5'd14: atan_tab = AW'(58671);
      5'd15: atan_tab = AW'(29335);
      5'd16: atan_tab = AW'(14668);
      5'd17: atan_tab = AW'(7334);
      5'd18: atan_tab = AW'(3667);
      5'd19: atan_tab = AW'(1833);
      5'd20: atan_tab = AW'(917);
      5'd21: atan_tab = AW'(458);
      5'd22: atan_tab = AW'(229);
      5'd23: atan_tab = AW'(115);
      default: atan_tab = '0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) sat32 = 32'sh8000_0000;
    else                          sat32 = v[31:0];
  endfunction

  // lane start-up request
  typedef struct packed {
    logic                 start;
    logic signed [16:0]   y;
    logic signed [16:0]   x;
  } lane_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [AW-1:0] angle;
  } lane_rsp_t;

endpackage

FILE: rtl/icf_cordic_lane.sv
// ----------------------------------------------------------------------------
// icf_cordic_lane: iterative vectoring CORDIC, one step per cycle
// Returns atan2(y, x) in Q8.24 degrees.
// ----------------------------------------------------------------------------
module icf_cordic_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icf_pkg::lane_req_t req_i,
  output icf_pkg::lane_rsp_t rsp_o
);
  import icf_pkg::*;

  logic                 busy_q, busy_d;
  logic [StepW-1:0]     step_q, step_d;
  logic signed [CW-1:0] xs_q, xs_d, ys_q, ys_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic                 done_q, done_d;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    xs_d   = xs_q;
    ys_d   = ys_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      step_d = '0;
      if (req_i.y == '0) begin
        acc_d  = (req_i.x >= 0) ? '0 : Deg180Q24;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        if (req_i.x < 0) begin
          xs_d  = -(CW'(req_i.x) <<< 16);
          ys_d  = -(CW'(req_i.y) <<< 16);
          acc_d = (req_i.y >= 0) ? Deg180Q24 : -Deg180Q24;
        end else begin
          xs_d  = CW'(req_i.x) <<< 16;
          ys_d  = CW'(req_i.y) <<< 16;
          acc_d = '0;
        end
      end
    end else if (busy_q) begin
      if (ys_q >= 0) begin
        xs_d  = xs_q + (ys_q >>> step_q);
        ys_d  = ys_q - (xs_q >>> step_q);
        acc_d = acc_q + atan_tab(5'(step_q));
      end else begin
        xs_d  = xs_q - (ys_q >>> step_q);
        ys_d  = ys_q + (xs_q >>> step_q);
        acc_d = acc_q - atan_tab(5'(step_q));
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q  <= xs_d;
    ys_q  <= ys_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = acc_q;
endmodule

FILE: rtl/icf_blend.sv
// ----------------------------------------------------------------------------
// icf_blend: merge stage, weighted mix of integrated and accel angle
// Products registered, then sum, round and saturate combinationally.
// ----------------------------------------------------------------------------
module icf_blend (
  input  logic                       clk_i,
  input  logic                       start_i,
  input  logic [15:0]                weight_i,
  input  logic signed [31:0]         angle_i,
  input  logic signed [icf_pkg::AW-1:0] acc_i,
  output logic signed [31:0]         result_o
);
  import icf_pkg::*;

  logic signed [AW-DegShift:0] a_rnd;
  logic signed [16:0]          wg;
  // complement weight reaches 65536 when the gyro weight is zero
  logic signed [17:0]          wa;
  logic signed [63:0]          pg_q, pa_q;
  logic signed [63:0]          sum;

  assign a_rnd = (AW - DegShift + 1)'((64'(acc_i) + 64'(1 <<< (DegShift - 1))) >>> DegShift);
  assign wg    = {1'b0, weight_i};
  assign wa    = 18'sd65536 - 18'(wg);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pg_q <= 64'(wg) * 64'(angle_i);
      pa_q <= 64'(wa) * 64'(a_rnd);
    end
  end

  assign sum      = (pg_q + pa_q + 64'sd32768) >>> 16;
  assign result_o = sat32(sum);
endmodule

FILE: rtl/imu_complementary_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_filter: accel + gyro attitude filter
// Path from the accepting edge to m_axis_tvalid with accel correction: integrate,
// lane start, 16 CORDIC steps, done, blend; the CORDIC steps are skipped when both
// arctangents are trivial (zero Y), and only the integrate state lies between without
// correction. One sample in flight; a new sample is accepted only once the output is taken.
// Reset: angles cleared, registers at defaults, no clearing pass.
// ----------------------------------------------------------------------------
module imu_complementary_filter
  import icf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // s_axis_tdata: acc_x, acc_y, acc_z, gyro_pitch_rate, gyro_roll_rate,
  //               gyro_yaw_rate, time_step (lowest bit first), 176 bits
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  // m_axis_tdata: pitch_out, roll_out, yaw_out, sample_used, accel_applied
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INTEG = 5'b00010,
    ST_CORD  = 5'b00100,
    ST_BLEND = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [14:0] noise_q;
  logic [16:0] mag_lo_q, mag_hi_q;
  logic [15:0] weight_q;
  logic [31:0] max_dt_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q  <= 15'd200;
      mag_lo_q <= 17'd8192;
      mag_hi_q <= 17'd32768;
      weight_q <= 16'd64225;
      max_dt_q <= 32'd83886080;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_NOISE:  noise_q  <= cfg_data_i[14:0];
        REG_MAG_LO: mag_lo_q <= cfg_data_i[16:0];
        REG_MAG_HI: mag_hi_q <= cfg_data_i[16:0];
        REG_WEIGHT: weight_q <= cfg_data_i[15:0];
        REG_MAX_DT: max_dt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack request
  logic signed [15:0] ax, ay, az;
  logic signed [31:0] rp, rr, ry;
  logic [31:0]        dt;
  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];
  assign rp = s_axis_tdata[79:48];
  assign rr = s_axis_tdata[111:80];
  assign ry = s_axis_tdata[143:112];
  assign dt = s_axis_tdata[175:144];

  logic in_fire;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // captured sample
  logic signed [16:0] cx_q, cy_q, cz_q;
  logic signed [63:0] dp_q, dr_q, dy_q;
  logic               used_q, apply_q;
  logic signed [31:0] pitch_q, roll_q, yaw_q;

  // magnitude and noise gating, combinational on the input word
  logic [16:0] absx, absy, absz, mag;
  assign absx = ax[15] ? 17'(-{ax[15], ax}) : 17'(ax);
  assign absy = ay[15] ? 17'(-{ay[15], ay}) : 17'(ay);
  assign absz = az[15] ? 17'(-{az[15], az}) : 17'(az);
  assign mag  = absx + absy + absz;

  function automatic logic signed [63:0] rnd24(input logic signed [63:0] p);
    rnd24 = (p + 64'sd8388608) >>> 24;
  endfunction

  lane_req_t req_p, req_r;
  lane_rsp_t rsp_p, rsp_r;
  logic      cord_go_q;
  logic      pdone_q, rdone_q;

  assign req_p.start = cord_go_q;
  assign req_p.y     = cy_q;
  assign req_p.x     = cz_q;
  assign req_r.start = cord_go_q;
  assign req_r.y     = cx_q;
  assign req_r.x     = cz_q;

  icf_cordic_lane u_lane_pitch (.clk_i, .rst_ni, .req_i(req_p), .rsp_o(rsp_p));
  icf_cordic_lane u_lane_roll  (.clk_i, .rst_ni, .req_i(req_r), .rsp_o(rsp_r));

  logic signed [31:0] bp, br;
  logic               blend_go;
  logic [1:0]         bcnt_q;
  assign blend_go = (state_q == ST_CORD) && (pdone_q || rsp_p.done)
                    && (rdone_q || rsp_r.done) && (bcnt_q == 2'd0);

  icf_blend u_blend_pitch (.clk_i, .start_i(blend_go), .weight_i(weight_q),
                           .angle_i(pitch_q), .acc_i(rsp_p.angle), .result_o(bp));
  icf_blend u_blend_roll  (.clk_i, .start_i(blend_go), .weight_i(weight_q),
                           .angle_i(roll_q), .acc_i(rsp_r.angle), .result_o(br));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_INTEG;
      ST_INTEG: state_d = apply_q ? ST_CORD : ST_OUT;
      ST_CORD:  if (blend_go) state_d = ST_BLEND;
      ST_BLEND: state_d = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pitch_q   <= '0;
      roll_q    <= '0;
      yaw_q     <= '0;
      used_q    <= 1'b0;
      apply_q   <= 1'b0;
      cord_go_q <= 1'b0;
      pdone_q   <= 1'b0;
      rdone_q   <= 1'b0;
      bcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      cord_go_q <= 1'b0;
      bcnt_q    <= '0;
      if (in_fire) begin
        used_q  <= (dt <= max_dt_q);
        apply_q <= (dt <= max_dt_q) && (mag > mag_lo_q) && (mag < mag_hi_q);
        pdone_q <= 1'b0;
        rdone_q <= 1'b0;
      end
      if (state_q == ST_INTEG && used_q) begin
        pitch_q   <= sat32(64'(pitch_q) + rnd24(dp_q));
        roll_q    <= sat32(64'(roll_q) + rnd24(dr_q));
        yaw_q     <= sat32(64'(yaw_q) + rnd24(dy_q));
        cord_go_q <= apply_q;
      end
      if (state_q == ST_CORD) begin
        if (rsp_p.done) pdone_q <= 1'b1;
        if (rsp_r.done) rdone_q <= 1'b1;
      end
      if (state_q == ST_BLEND) begin
        pitch_q <= bp;
        roll_q  <= br;
      end
    end
  end

  // payload capture; products of 32x32 registered before the add
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cx_q <= (absx < {2'b0, noise_q}) ? '0 : 17'(ax);
      cy_q <= (absy < {2'b0, noise_q}) ? '0 : 17'(ay);
      cz_q <= 17'(az);
      dp_q <= 64'(rp) * $signed({32'b0, dt});
      dr_q <= 64'(rr) * $signed({32'b0, dt});
      dy_q <= 64'(ry) * $signed({32'b0, dt});
    end
  end

  // CORDIC done pulses are held until both lanes finish; the angle regs hold.
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {6'b0, apply_q, used_q, yaw_q, roll_q, pitch_q};

  // assertions
  a_apply_implies_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!apply_q || used_q)) else $error("correction without use");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_lanes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_go_q |=> (state_q == ST_CORD)) else $error("lanes started off state");
endmodule
